### sv/access_profiler_and_trace_ring_defines.svh
// assertion macros used by the checker file
`ifndef ACCESS_PROFILER_AND_TRACE_RING_DEFINES_SVH
`define ACCESS_PROFILER_AND_TRACE_RING_DEFINES_SVH

// check on every clock edge, reset included
`define APTR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// check only while out of reset
`define APTR_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### sv/aptr_pkg.sv
package aptr_pkg;

    typedef enum logic [1:0] {
        EVT_FETCH   = 2'd0,
        EVT_READ    = 2'd1,
        EVT_WRITE   = 2'd2,
        EVT_INSPECT = 2'd3
    } t_event_kind;

    localparam logic [7:0] PCHL_OPCODE = 8'hE9;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  instr;
        logic [15:0] operand;
    } t_trace_entry;

    // request from the event front end to the trace ring
    typedef struct packed {
        logic         read;
        logic         push;
        logic [7:0]   offset;
        t_trace_entry entry;
    } t_ring_req;

    // selected entry, fields already zero when not valid
    typedef struct packed {
        logic         valid;
        t_trace_entry entry;
    } t_ring_rsp;

endpackage

### sv/aptr_if.sv
interface aptr_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] global_addr;
    logic [7:0]  instr_byte;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [15:0] hl_value;
    logic [7:0]  trace_offset;

    modport source (
        output valid, opcode, global_addr, instr_byte, operand_low, operand_high,
               hl_value, trace_offset,
        input  ready
    );
    modport sink (
        input  valid, opcode, global_addr, instr_byte, operand_low, operand_high,
               hl_value, trace_offset,
        output ready
    );
endinterface

interface aptr_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] run_count;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic        entry_valid;
    logic [15:0] entry_addr;
    logic [7:0]  entry_instr;
    logic [15:0] entry_operand;

    modport source (
        output valid, run_count, read_count, write_count, entry_valid, entry_addr,
               entry_instr, entry_operand,
        input  ready
    );
    modport sink (
        input  valid, run_count, read_count, write_count, entry_valid, entry_addr,
               entry_instr, entry_operand,
        output ready
    );
endinterface

### sv/aptr_trace_ring.sv
module aptr_trace_ring
    import aptr_pkg::*;
#(
    parameter int TRACE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_req i_req,
    output t_ring_rsp o_rsp
);

    localparam int TB = $clog2(TRACE_DEPTH);
    localparam int FB = $clog2(TRACE_DEPTH + 1);

    // offset reduced modulo depth, one compare-subtract per offset bit
    function automatic logic [TB-1:0] off_mod(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        for (int k = 7; k >= 0; k--) begin
            if (32'(r) >= (TRACE_DEPTH << k)) begin
                r = r - 8'(TRACE_DEPTH << k);
            end
        end
        return TB'(r);
    endfunction

    t_trace_entry mem_ring [TRACE_DEPTH];

    logic [TB-1:0] r_head;
    logic [FB-1:0] r_fill;
    logic [TB-1:0] n_head;
    logic [FB-1:0] n_fill;
    logic [TB-1:0] offm;
    logic [TB:0]   idx_sum;
    logic [TB-1:0] rd_idx;
    logic          sel_valid;

    logic          r_valid;
    logic          r_hit;
    t_trace_entry  r_rd;
    t_trace_entry  r_wr_entry;

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_req.push) begin
            n_head = (r_head == '0) ? TB'(TRACE_DEPTH - 1) : r_head - 1'b1;
            if (r_fill != FB'(TRACE_DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    assign offm      = off_mod(i_req.offset);
    assign idx_sum   = {1'b0, n_head} + {1'b0, offm};
    assign rd_idx    = (idx_sum >= (TB + 1)'(TRACE_DEPTH))
                       ? TB'(idx_sum - (TB + 1)'(TRACE_DEPTH)) : TB'(idx_sum);
    // entries are written backward from the head, so the first fill ones are live
    assign sel_valid = FB'(offm) < n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            if (i_req.read) begin
                r_valid <= sel_valid;
                r_hit   <= i_req.push && (offm == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            mem_ring[n_head] <= i_req.entry;
            r_wr_entry       <= i_req.entry;
        end
        if (i_req.read) begin
            r_rd <= mem_ring[rd_idx];
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.entry = !r_valid ? '0 : (r_hit ? r_wr_entry : r_rd);

endmodule

### sv/access_profiler_and_trace_ring.sv
// access profiler and instruction trace ring for an 8-bit cpu bus
//
// i_evt carries one bus event per transfer: fetch, read, write or inspect of
// global_addr. o_res returns exactly one result per event: the three counters
// of that address after the event and the trace entry trace_offset steps
// behind the newest one.
// flow: at the event transfer the counter memory and the trace ring are read into
// registers; when the output is free, the updated counters are written back and
// the output register loads, and the result transfer can follow. the next event
// is held off until that write-back is done, so a new event is never taken while
// one is still in flight.
// reset: a clearing pass writes zero to every counter word, one address per
// cycle; i_evt.ready stays low until it ends. the trace ring needs no pass, a
// fill count marks live entries.
// stall: a finished result waits in the output register; one more event can be
// taken and read meanwhile, its write-back waits until the output is free.
module access_profiler_and_trace_ring
    import aptr_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int TRACE_DEPTH = 256,
    parameter int COUNT_BITS  = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    aptr_event_if.sink  i_evt,
    aptr_result_if.source o_res
);

    localparam int CW = 3 * COUNT_BITS;

    // counter word: {write, read, run}
    logic [CW-1:0] mem_cnt [2**ADDR_BITS];

    // clearing pass after reset
    logic                 r_sweep;
    logic [ADDR_BITS-1:0] r_clr_addr;

    // event in flight between memory read and write-back
    logic                 r_busy;
    t_event_kind          r_kind;
    logic [ADDR_BITS-1:0] r_addr;
    logic [CW-1:0]        r_cnt_rd;

    // output register
    logic        r_out_valid;
    logic [31:0] r_run_count;
    logic [31:0] r_read_count;
    logic [31:0] r_write_count;
    t_ring_rsp   r_entry;

    logic                 evt_accept;
    logic                 out_free;
    logic                 wb;
    t_event_kind          evt_kind;
    logic [ADDR_BITS-1:0] evt_addr;
    t_ring_req            ring_req;
    t_ring_rsp            ring_rsp;

    logic [COUNT_BITS-1:0] run_n;
    logic [COUNT_BITS-1:0] read_n;
    logic [COUNT_BITS-1:0] write_n;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [CW-1:0]        mem_wdata;

    assign evt_kind    = t_event_kind'(i_evt.opcode);
    assign evt_addr    = ADDR_BITS'(i_evt.global_addr);
    // no new transfer while a write-back is pending, so a read never sees stale data
    assign i_evt.ready = !r_sweep && !r_busy;
    assign evt_accept  = i_evt.valid && i_evt.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign wb          = r_busy && out_free;

    // trace ring request, pchl records hl as its operand
    always_comb begin
        ring_req.read         = evt_accept;
        ring_req.push         = evt_accept && (evt_kind == EVT_FETCH);
        ring_req.offset       = i_evt.trace_offset;
        ring_req.entry.addr   = 16'(evt_addr);
        ring_req.entry.instr  = i_evt.instr_byte;
        ring_req.entry.operand = (i_evt.instr_byte == PCHL_OPCODE)
                                 ? i_evt.hl_value
                                 : {i_evt.operand_high, i_evt.operand_low};
    end

    aptr_trace_ring #(
        .TRACE_DEPTH(TRACE_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ring_req),
        .o_rsp  (ring_rsp)
    );

    // counter update, wraps at the counter width
    assign run_n   = r_cnt_rd[COUNT_BITS-1:0] + COUNT_BITS'(r_kind == EVT_FETCH);
    assign read_n  = r_cnt_rd[2*COUNT_BITS-1:COUNT_BITS] + COUNT_BITS'(r_kind == EVT_READ);
    assign write_n = r_cnt_rd[CW-1:2*COUNT_BITS] + COUNT_BITS'(r_kind == EVT_WRITE);

    assign mem_we    = r_sweep || wb;
    assign mem_waddr = r_sweep ? r_clr_addr : r_addr;
    assign mem_wdata = r_sweep ? '0 : {write_n, read_n, run_n};

    // counter memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_cnt[mem_waddr] <= mem_wdata;
        end
        if (evt_accept) begin
            r_cnt_rd <= mem_cnt[evt_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= 1'b1;
            r_clr_addr  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_sweep) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_sweep <= 1'b0;
                end
            end
            if (evt_accept) begin
                r_busy <= 1'b1;
            end else if (wb) begin
                r_busy <= 1'b0;
            end
            if (wb) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // event fields held for the write-back
    always_ff @(posedge i_clk) begin
        if (evt_accept) begin
            r_kind <= evt_kind;
            r_addr <= evt_addr;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (wb) begin
            r_run_count   <= 32'(run_n);
            r_read_count  <= 32'(read_n);
            r_write_count <= 32'(write_n);
            r_entry       <= ring_rsp;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.run_count     = r_run_count;
    assign o_res.read_count    = r_read_count;
    assign o_res.write_count   = r_write_count;
    assign o_res.entry_valid   = r_entry.valid;
    assign o_res.entry_addr    = r_entry.entry.addr;
    assign o_res.entry_instr   = r_entry.entry.instr;
    assign o_res.entry_operand = r_entry.entry.operand;

endmodule

### sv/aptr_checker.sv
`include "access_profiler_and_trace_ring_defines.svh"

module aptr_checker
    import aptr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_evt_valid,
    input logic       i_evt_ready,
    input logic [1:0] i_evt_opcode,
    input logic [7:0] i_evt_instr_byte,
    input logic [7:0] i_evt_trace_offset,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_res_entry_valid,
    input logic [7:0] i_res_entry_instr
);

    logic evt_xfer;
    logic res_free;

    assign evt_xfer = i_evt_valid && i_evt_ready;
    assign res_free = !i_res_valid || i_res_ready;

    `APTR_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!i_evt_ready && !i_res_valid), "ports not quiet after reset")

    `APTR_ASSERT_RUN(a_res_hold, i_clk, i_rst_n, (i_res_valid && !i_res_ready) |=> i_res_valid, "result dropped while stalled")

    `APTR_ASSERT_RUN(a_one_in_flight, i_clk, i_rst_n, evt_xfer |=> !i_evt_ready, "event taken during write-back")

    `APTR_ASSERT_RUN(a_fetch_own_entry, i_clk, i_rst_n, (evt_xfer && res_free && (i_evt_opcode == EVT_FETCH) && (i_evt_trace_offset == 8'd0)) |-> ##2 (i_res_valid && i_res_entry_valid && (i_res_entry_instr == $past(i_evt_instr_byte, 2))), "fetch result missing its own trace entry")

endmodule

bind access_profiler_and_trace_ring aptr_checker u_aptr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_evt_valid       (i_evt.valid),
    .i_evt_ready       (i_evt.ready),
    .i_evt_opcode      (i_evt.opcode),
    .i_evt_instr_byte  (i_evt.instr_byte),
    .i_evt_trace_offset(i_evt.trace_offset),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_entry_valid (o_res.entry_valid),
    .i_res_entry_instr (o_res.entry_instr)
);
